>>> rtl/mlf_pkg.sv
`timescale 1ns / 1ps

package mlf_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int MAC_W  = 48;
  localparam int PORT_W = 16;

  // Bit position of the group (multicast) flag: low bit of the first octet.
  localparam int MCAST_BIT = 40;

  // Verdict codes.
  typedef enum logic [1:0] {
    V_FORWARD = 2'd0,
    V_FLOOD   = 2'd1,
    V_DROP    = 2'd2
  } verdict_t;

  // One forwarding table entry.
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } entry_t;

  // Status returned by the scan unit when a search ends.
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [PORT_W-1:0] port;
  } scan_res_t;

endpackage

>>> rtl/mlf_table.sv
`timescale 1ns / 1ps

module mlf_table
  import mlf_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  // Entry storage; contents are meaningful only below the fill count.
  entry_t mem [TABLE_ENTRIES];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mlf_scan.sv
`timescale 1ns / 1ps

module mlf_scan
  import mlf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAC_W-1:0]  key,
  input  logic [CNT_W-1:0]  limit,
  input  entry_t            rd_data,
  output logic              rd_en,
  output logic [IDX_W-1:0]  rd_addr,
  output scan_res_t         res
);

  logic              active;
  logic [CNT_W-1:0]  cnt;
  logic              pipe_vld;
  logic [IDX_W-1:0]  pipe_idx;
  logic [MAC_W-1:0]  key_r;
  logic              done;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [PORT_W-1:0] hit_port;
  logic              match;
  logic              more;

  // The shared comparator looks at the entry read in the previous cycle.
  assign match = pipe_vld && (rd_data.mac == key_r);
  assign more  = (cnt < limit);

  // Issue one read per cycle while valid entries remain and no hit is seen.
  assign rd_en   = active && more && !match;
  assign rd_addr = cnt[IDX_W-1:0];

  // Scan sequencer: address counter, one-deep read pipe and the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pipe_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        cnt      <= '0;
        pipe_vld <= 1'b0;
        key_r    <= key;
      end else if (active) begin
        if (match) begin
          active   <= 1'b0;
          pipe_vld <= 1'b0;
          done     <= 1'b1;
          hit      <= 1'b1;
          hit_idx  <= pipe_idx;
          hit_port <= rd_data.port;
        end else if (more) begin
          pipe_vld <= 1'b1;
          pipe_idx <= cnt[IDX_W-1:0];
          cnt      <= cnt + 1'b1;
        end else begin
          active   <= 1'b0;
          pipe_vld <= 1'b0;
          done     <= 1'b1;
          hit      <= 1'b0;
          hit_idx  <= '0;
          hit_port <= '0;
        end
      end
    end
  end

  assign res.done = done;
  assign res.hit  = hit;
  assign res.idx  = hit_idx;
  assign res.port = hit_port;

endmodule

>>> rtl/mac_learning_forwarder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Word
// config    in         cfg_wr_en                  cfg_wr_data (learning enable)
// header    in         start high and busy low    src_mac, dst_mac, in_port
// result    out        result_valid, one cycle    verdict, out_port, flags
//
// A dropped or flooded header (bad address, learning off) returns its word in
// the cycle right after the accepting edge, and busy stays low. With learning
// on, busy stays high from the accepting edge until the word is given, and only
// then can the next header be accepted. Each search reads at most as many
// entries as the fill count it sees, so the time grows with the learned
// entries, and a hit cuts a search short. The source and then the destination
// are matched against the table one entry per cycle through a single
// registered memory read port and one shared comparator. Reset is synchronous
// and empties the table by clearing the fill count. The receiver cannot stall.

module mac_learning_forwarder
  import mlf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              start,
  output logic              busy,
  input  logic [MAC_W-1:0]  src_mac,
  input  logic [MAC_W-1:0]  dst_mac,
  input  logic [PORT_W-1:0] in_port,
  output logic              result_valid,
  output logic [1:0]        verdict,
  output logic [PORT_W-1:0] out_port,
  output logic              learned_new,
  output logic              station_moved,
  output logic              table_full
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRC,
    S_DST
  } state_t;

  state_t            state;
  logic              learning_enable;
  logic [CNT_W-1:0]  fill_count;
  logic [MAC_W-1:0]  src_r;
  logic [MAC_W-1:0]  dst_r;
  logic [PORT_W-1:0] port_r;
  logic              learned;
  logic              moved;
  logic              full;

  logic              accept;
  logic              bad_addr;
  logic              scan_start;
  logic [MAC_W-1:0]  scan_key;
  scan_res_t         sres;
  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  entry_t            tbl_wdata;
  logic              tbl_re;
  logic [IDX_W-1:0]  tbl_raddr;
  entry_t            tbl_rdata;
  logic              src_done;
  logic              has_room;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign bad_addr = (src_mac == '0) || (dst_mac == '0) || src_mac[MCAST_BIT];
  assign src_done = (state == S_SRC) && sres.done;
  assign has_room = (fill_count < CNT_W'(TABLE_ENTRIES));

  // Launch the source search on a learnable word, the destination search
  // right after the source search ends.
  assign scan_start = (accept && !bad_addr && learning_enable) || src_done;
  assign scan_key   = (state == S_IDLE) ? src_mac : dst_r;

  // Table update at the end of the source search: a move rewrites the port,
  // an unknown source takes the next free slot while there is room.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = fill_count[IDX_W-1:0];
    tbl_wdata.mac  = src_r;
    tbl_wdata.port = port_r;
    if (src_done) begin
      if (sres.hit) begin
        tbl_waddr = sres.idx;
        tbl_we    = (sres.port != port_r);
      end else begin
        tbl_we    = has_room;
      end
    end
  end

  mlf_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  mlf_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .key     (scan_key),
    .limit   (fill_count),
    .rd_data (tbl_rdata),
    .rd_en   (tbl_re),
    .rd_addr (tbl_raddr),
    .res     (sres)
  );

  // Learning enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      learning_enable <= cfg_wr_data;
    end
  end

  // Sequencer with the fill count and the registered result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            src_r   <= src_mac;
            dst_r   <= dst_mac;
            port_r  <= in_port;
            learned <= 1'b0;
            moved   <= 1'b0;
            full    <= 1'b0;
            if (bad_addr || !learning_enable) begin
              result_valid  <= 1'b1;
              verdict       <= bad_addr ? V_DROP : V_FLOOD;
              out_port      <= '0;
              learned_new   <= 1'b0;
              station_moved <= 1'b0;
              table_full    <= 1'b0;
            end else begin
              state <= S_SRC;
            end
          end
        end
        S_SRC: begin
          if (sres.done) begin
            state <= S_DST;
            if (sres.hit) begin
              moved <= (sres.port != port_r);
            end else if (has_room) begin
              fill_count <= fill_count + 1'b1;
              learned    <= 1'b1;
            end else begin
              full <= 1'b1;
            end
          end
        end
        S_DST: begin
          if (sres.done) begin
            state         <= S_IDLE;
            result_valid  <= 1'b1;
            verdict       <= sres.hit ? V_FORWARD : V_FLOOD;
            out_port      <= sres.hit ? sres.port : '0;
            learned_new   <= learned;
            station_moved <= moved;
            table_full    <= full;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  // At most one learning flag is reported per word.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({learned_new, station_moved, table_full}))
    else $error("conflicting learning flags");

  // The end of the destination search always yields a result word.
  a_dst_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DST && sres.done) |=> (result_valid && state == S_IDLE))
    else $error("destination search ended without result");

  // The table is written only as the source search completes.
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (state == S_SRC && sres.done))
    else $error("table write outside update window");

  // A new entry always raises the fill count by one.
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (src_done && !sres.hit && has_room) |=> (fill_count == $past(fill_count) + 1'b1))
    else $error("fill count did not advance on insert");

endmodule
